/* hdl/kmer_codebook_matcher_core_defines.svh */
// Assertion macros shared by the checker files of the K-mer matcher.
`ifndef KMER_CODEBOOK_MATCHER_CORE_DEFINES_SVH
`define KMER_CODEBOOK_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KCM_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KCM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/kcm_pkg.sv */
// Shared types, codes and helpers of the K-mer codebook matcher.
package kcm_pkg;

	// fixed field widths of the request and response words
	localparam int KEY_IN_W  = 20;
	localparam int QUERY_W   = 20;
	localparam int RSP_IDX_W = 20;
	localparam int RSP_CNT_W = 32;

	// request kinds
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_BASE = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// response status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// ASCII of the four bases
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;

	// response queue
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_LVL_W = 3;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [7:0]          base_char;
		logic                seq_start;
		logic [KEY_IN_W-1:0] load_key;
		logic [QUERY_W-1:0]  query_index;
	} kcm_req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic                 matched;
		logic [RSP_IDX_W-1:0] match_index;
		logic [RSP_CNT_W-1:0] count_value;
		logic [RSP_CNT_W-1:0] hit_total;
	} kcm_rsp_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} kcm_base_t;

	// A=0 C=1 G=2 T=3; anything else is not a base
	function automatic kcm_base_t base_code(input logic [7:0] c);
		kcm_base_t b;
		b = '0;
		unique case (c)
			CHAR_A: b = '{ok: 1'b1, code: 2'd0};
			CHAR_C: b = '{ok: 1'b1, code: 2'd1};
			CHAR_G: b = '{ok: 1'b1, code: 2'd2};
			CHAR_T: b = '{ok: 1'b1, code: 2'd3};
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

/* hdl/kcm_channels.sv */
// Valid/ready channel interfaces for request and response words.
interface kcm_req_if;
	import kcm_pkg::*;
	logic     valid;
	logic     ready;
	kcm_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface kcm_rsp_if;
	import kcm_pkg::*;
	logic     valid;
	logic     ready;
	kcm_rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hdl/kcm_out_fifo.sv */
// Response queue: holds finished words until the receiver takes them.
module kcm_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  kcm_pkg::kcm_rsp_t              push_data,
	output logic [kcm_pkg::OUT_LVL_W-1:0]  level,
	kcm_rsp_if.source                      rsp
);
	import kcm_pkg::*;

	kcm_rsp_t              slot_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wr_ptr_q;
	logic [OUT_PTR_W-1:0]  rd_ptr_q;
	logic [OUT_LVL_W-1:0]  level_q;
	logic                  pop;

	assign pop       = rsp.valid && rsp.ready;
	assign rsp.valid = (level_q != '0);
	assign rsp.data  = slot_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

/* hdl/kmer_codebook_matcher_core.sv */
// Top level of the K-mer codebook matcher.
// Usage: one request word per req handshake, one response word per request on rsp,
//   in request order. req_type selects load key, sequence base or histogram read.
// A load enters the key in the codebook under the next free index; a base byte
//   shifts into the K-base window and, when the window holds a known key, reports a hit
//   and bumps the per-index histogram and the hit total.
// Throughput: one request per cycle, any mix of kinds, no bubbles between words while rsp keeps up.
// Each response word passes the stage 1 and stage 2 registers and the response queue to rsp.
// Loop behind the rate: codebook read (stage 1) decides the hit; the histogram
//   read-modify-write spans stages 1-2. Same-entry overlaps are forwarded.
// The window register is updated speculatively at acceptance and emptied in the next
//   cycle if that base hit, which is the earliest the next base needs it.
// Reset: control state clears at once; then a clearing pass writes every codebook
//   and histogram entry, with req.ready held low.
// Stall: a four-word response queue absorbs rsp stalls; req.ready drops when queue
//   words plus words in flight already fill it, so nothing is lost or dropped.
module kmer_codebook_matcher_core #(
	parameter int KMER_LEN   = 10,
	parameter int INDEX_BITS = 20,
	parameter int COUNT_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	kcm_req_if.sink   req,
	kcm_rsp_if.source rsp
);
	import kcm_pkg::*;

	localparam int KEY_BITS   = 2 * KMER_LEN;
	localparam int FILL_BITS  = $clog2(KMER_LEN + 1);
	localparam int CLR_BITS   = (KEY_BITS > INDEX_BITS) ? KEY_BITS : INDEX_BITS;
	localparam int ENTRY_BITS = INDEX_BITS + 1;
	localparam int BOOK_DEPTH = 1 << KEY_BITS;
	localparam int HIST_DEPTH = 1 << INDEX_BITS;
	localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(KMER_LEN);

	// ---------------- storage ----------------
	// codebook entry: {valid, index}
	logic [ENTRY_BITS-1:0] book_mem [BOOK_DEPTH];
	logic [COUNT_BITS-1:0] hist_mem [HIST_DEPTH];

	// ---------------- clearing pass ----------------
	logic [CLR_BITS:0] clr_cnt_q;
	logic              clearing;

	assign clearing = !clr_cnt_q[CLR_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// ---------------- stage 0: accept, window, codebook read ----------------
	logic                  accept;
	kcm_req_t              rq;
	kcm_base_t             bc;
	logic                  is_base;
	logic [KEY_BITS-1:0]   win_code_q;
	logic [FILL_BITS-1:0]  win_fill_q;
	logic [KEY_BITS-1:0]   wbase_code, start_code, shift_code, win_code_nxt;
	logic [FILL_BITS-1:0]  wbase_fill, start_fill, shift_fill, win_fill_nxt;
	logic                  lookup_s0;
	logic [KEY_BITS-1:0]   bk_rd_addr;
	logic [OUT_LVL_W-1:0]  out_level;
	logic                  hit_s1;

	// book write port (stage 1 or clearing pass)
	logic                  bk_we;
	logic [KEY_BITS-1:0]   bk_wa;
	logic [ENTRY_BITS-1:0] bk_wd;

	// stage 1 registers
	logic                  v_s1, lookup_s1, bk_fwd_s1;
	logic [1:0]            type_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [QUERY_W-1:0]    query_s1;
	logic [ENTRY_BITS-1:0] bk_rd_s1, bk_fwd_data_s1;

	// stage 2 registers
	logic                  v_s2, hit_s2, rdq_s2, h_fwd_s2;
	logic [1:0]            status_s2;
	logic [INDEX_BITS-1:0] idx_s2, haddr_s2;
	logic [RSP_CNT_W-1:0]  total_s2;
	logic [COUNT_BITS-1:0] h_rd_s2, h_fwd_data_s2;

	assign rq      = req.data;
	assign accept  = req.valid && req.ready;
	assign is_base = (rq.req_type == REQ_BASE);
	assign bc      = base_code(rq.base_char);

	// credit: queue words plus words still in the pipe must leave a free slot
	assign req.ready = !clearing &&
		((out_level + OUT_LVL_W'(v_s1) + OUT_LVL_W'(v_s2)) < OUT_LVL_W'(OUT_DEPTH));

	always_comb begin
		// a hit on the base now in stage 1 empties the window it left behind
		wbase_code = hit_s1 ? '0 : win_code_q;
		wbase_fill = hit_s1 ? '0 : win_fill_q;
		start_code = rq.seq_start ? '0 : wbase_code;
		start_fill = rq.seq_start ? '0 : wbase_fill;
		shift_code = {start_code[KEY_BITS-3:0], bc.code};
		shift_fill = (start_fill == FILL_FULL) ? start_fill : start_fill + 1'b1;
		lookup_s0  = bc.ok && (shift_fill == FILL_FULL);
		if (accept && is_base) begin
			win_code_nxt = bc.ok ? shift_code : '0;
			win_fill_nxt = bc.ok ? shift_fill : '0;
		end else begin
			win_code_nxt = wbase_code;
			win_fill_nxt = wbase_fill;
		end
		bk_rd_addr = (rq.req_type == REQ_LOAD) ? KEY_BITS'(rq.load_key) : shift_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_code_q <= '0;
			win_fill_q <= '0;
			v_s1       <= 1'b0;
			lookup_s1  <= 1'b0;
			bk_fwd_s1  <= 1'b0;
		end else begin
			win_code_q <= win_code_nxt;
			win_fill_q <= win_fill_nxt;
			v_s1       <= accept;
			lookup_s1  <= accept && is_base && lookup_s0;
			// a write landing this cycle is not seen by the read: forward it
			bk_fwd_s1  <= bk_we && (bk_wa == bk_rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		type_s1        <= rq.req_type;
		key_s1         <= bk_rd_addr;
		query_s1       <= rq.query_index;
		bk_fwd_data_s1 <= bk_wd;
	end

	always_ff @(posedge clk) begin
		if (bk_we) book_mem[bk_wa] <= bk_wd;
		bk_rd_s1 <= book_mem[bk_rd_addr];
	end

	// ---------------- stage 1: hit / load decision, histogram read ----------------
	logic [ENTRY_BITS-1:0] bk_entry;
	logic                  ent_ok;
	logic [INDEX_BITS-1:0] ent_idx;
	logic                  is_load_s1, book_full, load_new, rd_ok_s1;
	logic [1:0]            status_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [INDEX_BITS:0]   next_idx_q;
	logic [COUNT_BITS-1:0] total_q, total_nxt;
	logic [RSP_CNT_W-1:0]  total_clip;
	logic [INDEX_BITS-1:0] h_rd_addr;
	logic [31:0]           query_ext;

	logic                  hw_en;
	logic [INDEX_BITS-1:0] hw_addr;
	logic [COUNT_BITS-1:0] hw_data;

	assign bk_entry   = bk_fwd_s1 ? bk_fwd_data_s1 : bk_rd_s1;
	assign ent_ok     = bk_entry[INDEX_BITS];
	assign ent_idx    = bk_entry[INDEX_BITS-1:0];
	assign is_load_s1 = v_s1 && (type_s1 == REQ_LOAD);
	assign book_full  = next_idx_q[INDEX_BITS];
	assign load_new   = is_load_s1 && !ent_ok && !book_full;
	assign hit_s1     = v_s1 && lookup_s1 && ent_ok;
	assign query_ext  = 32'(query_s1);
	assign rd_ok_s1   = v_s1 && (type_s1 == REQ_READ) && ((query_ext >> INDEX_BITS) == '0);
	assign h_rd_addr  = hit_s1 ? ent_idx : INDEX_BITS'(query_s1);
	assign total_nxt  = (hit_s1 && (total_q != '1)) ? total_q + 1'b1 : total_q;

	always_comb begin
		status_s1 = ST_OK;
		idx_s1    = '0;
		if (is_load_s1) begin
			if (ent_ok) begin
				status_s1 = ST_DUP;
				idx_s1    = ent_idx;
			end else if (book_full) begin
				status_s1 = ST_FULL;
			end else begin
				idx_s1 = next_idx_q[INDEX_BITS-1:0];
			end
		end else if (hit_s1) begin
			idx_s1 = ent_idx;
		end
		if (clearing) begin
			bk_we = 1'b1;
			bk_wa = clr_cnt_q[KEY_BITS-1:0];
			bk_wd = '0;
		end else begin
			bk_we = load_new;
			bk_wa = key_s1;
			bk_wd = {1'b1, next_idx_q[INDEX_BITS-1:0]};
		end
	end

	// counts wider than the response field show as all ones
	if (COUNT_BITS > RSP_CNT_W) begin : g_total_clip
		assign total_clip = (|total_nxt[COUNT_BITS-1:RSP_CNT_W]) ? '1
			: total_nxt[RSP_CNT_W-1:0];
	end else begin : g_total_ext
		assign total_clip = RSP_CNT_W'(total_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_idx_q <= '0;
			total_q    <= '0;
			v_s2       <= 1'b0;
			hit_s2     <= 1'b0;
			h_fwd_s2   <= 1'b0;
		end else begin
			if (load_new) next_idx_q <= next_idx_q + 1'b1;
			total_q  <= total_nxt;
			v_s2     <= v_s1;
			hit_s2   <= hit_s1;
			h_fwd_s2 <= hw_en && (hw_addr == h_rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		rdq_s2        <= rd_ok_s1;
		status_s2     <= status_s1;
		idx_s2        <= idx_s1;
		haddr_s2      <= h_rd_addr;
		total_s2      <= total_clip;
		h_fwd_data_s2 <= hw_data;
	end

	always_ff @(posedge clk) begin
		if (hw_en) hist_mem[hw_addr] <= hw_data;
		h_rd_s2 <= hist_mem[h_rd_addr];
	end

	// ---------------- stage 2: histogram update, response ----------------
	logic [COUNT_BITS-1:0] h_data, h_inc, count_full;
	logic [RSP_CNT_W-1:0]  count_clip;
	kcm_rsp_t              rsp_word;

	assign h_data     = h_fwd_s2 ? h_fwd_data_s2 : h_rd_s2;
	assign h_inc      = (h_data == '1) ? h_data : h_data + 1'b1;
	assign count_full = hit_s2 ? h_inc : (rdq_s2 ? h_data : '0);

	always_comb begin
		if (clearing) begin
			hw_en   = 1'b1;
			hw_addr = clr_cnt_q[INDEX_BITS-1:0];
			hw_data = '0;
		end else begin
			hw_en   = hit_s2;
			hw_addr = haddr_s2;
			hw_data = h_inc;
		end
	end

	if (COUNT_BITS > RSP_CNT_W) begin : g_count_clip
		assign count_clip = (|count_full[COUNT_BITS-1:RSP_CNT_W]) ? '1
			: count_full[RSP_CNT_W-1:0];
	end else begin : g_count_ext
		assign count_clip = RSP_CNT_W'(count_full);
	end

	assign rsp_word.status      = status_s2;
	assign rsp_word.matched     = hit_s2;
	assign rsp_word.match_index = RSP_IDX_W'(idx_s2);
	assign rsp_word.count_value = count_clip;
	assign rsp_word.hit_total   = total_s2;

	kcm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (rsp_word),
		.level     (out_level),
		.rsp       (rsp)
	);

endmodule

/* hdl/kcm_checker.sv */
// Port-level checks of the K-mer matcher, bound to the top level.
`include "kmer_codebook_matcher_core_defines.svh"

module kcm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input kcm_pkg::kcm_rsp_t rsp_data
);
	import kcm_pkg::*;

	logic [3:0]           pending_q;
	logic [RSP_CNT_W-1:0] last_total_q;
	logic                 req_acc, rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_total_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(req_acc) - 4'(rsp_acc);
			if (rsp_acc) last_total_q <= rsp_data.hit_total;
		end
	end

	// a stalled response word holds
	`KCM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")
	// no response without a request behind it
	`KCM_ASSERT_NOW(a_rsp_owed, rsp_valid, pending_q != '0, "rsp word without a pending request")
	// the running total never goes back
	`KCM_ASSERT_NOW(a_total_mono, rsp_valid, rsp_data.hit_total >= last_total_q, "hit total decreased")
	// a hit moves the total forward unless it is pinned at all ones
	`KCM_ASSERT_NOW(a_hit_counts, rsp_valid && rsp_data.matched, (rsp_data.hit_total > last_total_q) || (rsp_data.hit_total == '1), "hit not counted in total")

endmodule

bind kmer_codebook_matcher_core kcm_checker u_kcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

/* tb/tb_kmer_codebook_matcher_core.sv */
// Self-checking testbench for the K-mer codebook matcher core.
`timescale 1ns / 100ps

module tb_kmer_codebook_matcher_core;
	import kcm_pkg::*;

	// block configuration as instantiated (defaults)
	localparam int KMER      = 10;
	localparam int KEY_W     = 2 * KMER;
	localparam int SLOTS     = 1 << 20;
	localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;

	// request kind that the block ignores
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int N_RANDOM  = 400;
	localparam int TAIL_CYC  = 16;
	localparam int MAX_NOTES = 10;

	logic clk;
	logic arst_n;

	kcm_req_if req();
	kcm_rsp_if rsp();

	kmer_codebook_matcher_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// ------------------------------------------------------------------
	// Clock and reset. Reset goes low just after time zero so the async
	// reset branches drive every block input before the first edge.
	// ------------------------------------------------------------------
	initial begin
		clk    = 1'b0;
		arst_n = 1'b1;
		#1 arst_n = 1'b0;
		fork
			forever #10 clk = ~clk;
			begin
				repeat (4) @(posedge clk);
				@(negedge clk) arst_n = 1'b1;
			end
		join_none
	end

	// ------------------------------------------------------------------
	// Predictor state: sliding window, codebook, per-index hit histogram.
	// Codebook and histogram are sparse; a missing entry is invalid / zero.
	// ------------------------------------------------------------------
	logic [KEY_W-1:0]      win_key;
	int                    win_len;
	logic [19:0]           book_slot [logic [KEY_W-1:0]];
	longint unsigned       hit_hist  [logic [19:0]];
	int                    next_slot;
	longint unsigned       hits_sum;

	// stimulus and expected response words
	kcm_req_t              req_backlog [$];
	kcm_rsp_t              rsp_due     [$];
	logic [KEY_W-1:0]      loaded_keys [$];	// keys the generator has loaded

	// run bookkeeping
	int n_mismatch = 0;
	int n_checked  = 0;
	int n_load = 0, n_refused = 0, n_base = 0, n_hit = 0, n_read = 0, n_unused = 0;

	function automatic logic [31:0] sat32(input longint unsigned v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// Advance the predictor by one accepted request word and build its response.
	task automatic score_request(input kcm_req_t w, output kcm_rsp_t r);
		logic [1:0] code;
		logic       is_base;
		logic [19:0] slot;
		r = '0;
		case (w.req_type)
			REQ_LOAD: begin
				if (book_slot.exists(w.load_key)) begin
					// duplicate wins over full: report the slot it already has
					r.status      = ST_DUP;
					r.match_index = book_slot[w.load_key];
				end else if (next_slot >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					r.match_index         = next_slot[19:0];
					book_slot[w.load_key] = next_slot[19:0];
					next_slot++;
				end
			end
			REQ_BASE: begin
				is_base = 1'b1;
				code    = 2'd0;
				case (w.base_char)
					CHAR_A: code = 2'd0;
					CHAR_C: code = 2'd1;
					CHAR_G: code = 2'd2;
					CHAR_T: code = 2'd3;
					default: is_base = 1'b0;
				endcase
				// new sequence or a non-base byte: window starts over
				if (w.seq_start || !is_base) begin
					win_key = '0;
					win_len = 0;
				end
				if (is_base) begin
					win_key = {win_key[KEY_W-3:0], code};
					if (win_len < KMER)
						win_len++;
					if (win_len >= KMER && book_slot.exists(win_key)) begin
						slot          = book_slot[win_key];
						r.matched     = 1'b1;
						r.match_index = slot;
						if (!hit_hist.exists(slot))
							hit_hist[slot] = '0;
						if (hit_hist[slot] < CNT_MAX)
							hit_hist[slot]++;
						if (hits_sum < CNT_MAX)
							hits_sum++;
						r.count_value = sat32(hit_hist[slot]);
						// a hit consumes the window; a miss just slides it
						win_key = '0;
						win_len = 0;
					end
				end
			end
			REQ_READ: begin
				if (hit_hist.exists(w.query_index))
					r.count_value = sat32(hit_hist[w.query_index]);
			end
			default: ;	// unused kind: no state change
		endcase
		r.hit_total = sat32(hits_sum);
	endtask

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------
	function automatic logic [7:0] base_letter(input logic [1:0] code);
		case (code)
			2'd0: return CHAR_A;
			2'd1: return CHAR_C;
			2'd2: return CHAR_G;
			default: return CHAR_T;
		endcase
	endfunction

	// fields a kind does not use carry random values; the block must ignore them
	function automatic kcm_req_t rand_word(input logic [1:0] kind);
		kcm_req_t w;
		w.req_type    = kind;
		w.base_char   = 8'($urandom_range(0, 255));
		w.seq_start   = 1'($urandom_range(0, 1));
		w.load_key    = KEY_IN_W'($urandom);
		w.query_index = QUERY_W'($urandom);
		return w;
	endfunction

	task automatic add_load(input logic [KEY_W-1:0] key);
		kcm_req_t w;
		bit       seen;
		w          = rand_word(REQ_LOAD);
		w.load_key = key;
		req_backlog.insert(req_backlog.size(), w);
		seen = 1'b0;
		foreach (loaded_keys[i])
			if (loaded_keys[i] == key)
				seen = 1'b1;
		if (!seen)
			loaded_keys.insert(loaded_keys.size(), key);
	endtask

	task automatic add_base(input logic [7:0] c, input logic start);
		kcm_req_t w;
		w           = rand_word(REQ_BASE);
		w.base_char = c;
		w.seq_start = start;
		req_backlog.insert(req_backlog.size(), w);
	endtask

	task automatic add_read(input logic [19:0] idx);
		kcm_req_t w;
		w             = rand_word(REQ_READ);
		w.query_index = idx;
		req_backlog.insert(req_backlog.size(), w);
	endtask

	// A run of bases: a few random lead-in bases, then a key (mostly a loaded
	// one) spelled out, with the odd noise byte or restart sprinkled in.
	task automatic add_stretch();
		int               lead;
		logic [KEY_W-1:0] key;
		logic [7:0]       c;
		logic             start;
		lead = $urandom_range(0, 4);
		if (loaded_keys.size() > 0 && $urandom_range(0, 3) != 0)
			key = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
		else
			key = KEY_W'($urandom);
		for (int i = 0; i < lead; i++)
			add_base(base_letter(2'($urandom_range(0, 3))),
			         i == 0 && $urandom_range(0, 4) != 0);
		for (int i = KMER - 1; i >= 0; i--) begin
			c     = base_letter(key[2*i +: 2]);
			start = (lead == 0 && i == KMER - 1) ? ($urandom_range(0, 4) != 0)
			                                     : ($urandom_range(0, 99) < 3);
			if ($urandom_range(0, 99) < 4)
				c = 8'($urandom_range(0, 255));	// noise byte, almost never a base
			add_base(c, start);
		end
	endtask

	task automatic build_stimulus();
		int       pick;
		int       goal;
		// directed: extreme keys, duplicates, reads, ignored kind, non-base bytes
		add_load(20'h00000);		// all A
		add_load(20'hFFFFF);		// all T
		add_load(20'h1B1B1);		// ACGTACGTAC
		add_load(20'h00000);		// duplicate
		add_load(20'hFFFFF);		// duplicate
		add_read(20'h00000);
		add_read(20'hFFFFF);		// never loaded, reads zero
		req_backlog.insert(req_backlog.size(), rand_word(REQ_UNUSED));
		add_base(CHAR_C, 1'b1);
		add_base(8'hFF, 1'b0);		// non-base empties the window
		add_base(8'h61, 1'b0);		// lowercase a is not a base
		for (int i = 0; i < KMER; i++)
			add_base(CHAR_A, 1'b0);	// last one hits slot 0
		add_read(20'h00000);
		add_base(CHAR_G, 1'b1);
		add_base(8'h00, 1'b0);

		// random mix, dominated by base runs that can complete a key
		goal = req_backlog.size() + N_RANDOM;
		while (req_backlog.size() < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				if (loaded_keys.size() > 0 && $urandom_range(0, 4) == 0)
					add_load(loaded_keys[$urandom_range(0, loaded_keys.size() - 1)]);
				else
					add_load(KEY_W'($urandom));
			end else if (pick < 25) begin
				if ($urandom_range(0, 3) != 0)
					add_read(20'($urandom_range(0, loaded_keys.size() + 1)));
				else
					add_read(20'($urandom));
			end else if (pick < 27) begin
				req_backlog.insert(req_backlog.size(), rand_word(REQ_UNUSED));
			end else begin
				add_stretch();
			end
		end
	endtask

	// Gap length: mostly zero or short, a few long; while calm > 0 no gaps at all.
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm = $urandom_range(10, 50);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Request driver: pops the backlog, inserts idle gaps, and scores every
	// word the block accepts.
	// ------------------------------------------------------------------
	int req_idle;
	int req_calm;

	always @(posedge clk or negedge arst_n) begin : drive_req
		kcm_rsp_t r;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data  <= '0;
			req_idle  <= 0;
			req_calm   = 0;
		end else begin
			if (req.valid && req.ready) begin
				score_request(req.data, r);
				rsp_due.insert(rsp_due.size(), r);
				case (req.data.req_type)
					REQ_LOAD: begin
						n_load++;
						if (r.status != ST_OK)
							n_refused++;
					end
					REQ_BASE: begin
						n_base++;
						if (r.matched)
							n_hit++;
					end
					REQ_READ: n_read++;
					default:  n_unused++;
				endcase
			end
			// hold the word until it is taken
			if (!req.valid || req.ready) begin
				if (req_idle > 0) begin
					req.valid <= 1'b0;
					req_idle  <= req_idle - 1;
				end else if (req_backlog.size() > 0) begin
					req.valid <= 1'b1;
					req.data  <= req_backlog.pop_front();
					req_idle  <= pick_gap(req_calm);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response side: random backpressure, then in-order compare.
	// ------------------------------------------------------------------
	int rsp_stall;
	int rsp_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_stall <= 0;
			rsp_calm   = 0;
		end else if (rsp_stall > 0) begin
			rsp.ready <= 1'b0;
			rsp_stall <= rsp_stall - 1;
		end else begin
			rsp.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				rsp_stall <= pick_gap(rsp_calm);
		end
	end

	task automatic note_mismatch(input string what, input longint unsigned want,
	                             input longint unsigned got);
		n_mismatch++;
		if (n_mismatch <= MAX_NOTES)
			$display("%t: %s mismatch on response %0d: expected %0h, got %0h",
			         $realtime, what, n_checked, want, got);
	endtask

	always @(posedge clk) begin : check_rsp
		kcm_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp_due.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= MAX_NOTES)
					$display("%t: response word with nothing outstanding: %h",
					         $realtime, rsp.data);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.data.status !== want.status)
					note_mismatch("status", 64'(want.status), 64'(rsp.data.status));
				if (rsp.data.matched !== want.matched)
					note_mismatch("matched", 64'(want.matched), 64'(rsp.data.matched));
				if (rsp.data.match_index !== want.match_index)
					note_mismatch("match_index", 64'(want.match_index),
					              64'(rsp.data.match_index));
				if (rsp.data.count_value !== want.count_value)
					note_mismatch("count_value", 64'(want.count_value),
					              64'(rsp.data.count_value));
				if (rsp.data.hit_total !== want.hit_total)
					note_mismatch("hit_total", 64'(want.hit_total),
					              64'(rsp.data.hit_total));
				n_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: build stimulus, wait for everything to drain, report.
	// ------------------------------------------------------------------
	initial begin
		win_key   = '0;
		win_len   = 0;
		next_slot = 0;
		hits_sum  = '0;
		build_stimulus();
		// the block clears its stores before taking requests
		@(posedge arst_n);
		while (req_backlog.size() != 0 || req.valid || rsp_due.size() != 0)
			@(posedge clk);
		// stray words after the last expected one would still be flagged here
		repeat (TAIL_CYC) @(posedge clk);
		$display("Covered %0d loads (%0d refused), %0d bases with %0d hits,",
		         n_load, n_refused, n_base, n_hit);
		$display("%0d reads, %0d unused; %0d response words compared, %0d mismatches",
		         n_read, n_unused, n_checked, n_mismatch);
		if (n_mismatch == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: clearing pass plus the traffic, many times over.
	initial begin
		#100000000;
		$display("Timeout with %0d words still outstanding", rsp_due.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
